// ----- rtl/core/urm_pkg.sv -----
`timescale 1ns / 1ps

package urm_pkg;

    localparam logic [7:0] HDR_WRITE  = 8'hA8;
    localparam logic [7:0] HDR_READ   = 8'h58;
    localparam logic [7:0] UNLOCK_REG = 8'h1A;
    localparam logic [7:0] UNLOCK_KEY = 8'h55;
    // ~(A8 + 1A + 55 + 00 + 00)
    localparam logic [7:0] UNLOCK_CS  = ~(HDR_WRITE + UNLOCK_REG + UNLOCK_KEY);

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RXB   = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic ERR_TIMEOUT  = 1'b0;
    localparam logic ERR_CHECKSUM = 1'b1;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        JOB_READ,
        JOB_WRITE,
        JOB_DONE,
        JOB_FAIL
    } job_kind_t;

    // aux: write frame checksum for JOB_WRITE, error code in bit 0 for JOB_FAIL
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  addr;
        logic [23:0] data;
        logic [7:0]  aux;
    } job_t;

endpackage

// ----- rtl/core/urm_front.sv -----
`timescale 1ns / 1ps

module urm_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 in_accept,
    input  logic [1:0]           in_op,
    input  logic [7:0]           in_addr,
    input  logic [23:0]          in_value,
    input  logic [7:0]           in_rx,
    output logic                 job_push,
    output urm_pkg::job_t        job
);

    logic [15:0] timeout_reg;
    logic        pending_reg,   pending_next;
    logic [7:0]  addr_reg,      addr_next;
    logic [1:0]  count_reg,     count_next;
    logic [7:0]  byte0_reg,     byte0_next;
    logic [7:0]  byte1_reg,     byte1_next;
    logic [7:0]  byte2_reg,     byte2_next;
    logic [15:0] wait_reg,      wait_next;

    logic [7:0]  reply_cs;
    logic [7:0]  write_cs;
    logic [7:0]  check_byte;
    logic        finish;

    assign reply_cs = ~(urm_pkg::HDR_READ + addr_reg + byte0_reg + byte1_reg + byte2_reg);
    assign write_cs = ~(urm_pkg::HDR_WRITE + in_addr + in_value[7:0]
                        + in_value[15:8] + in_value[23:16]);

    always_comb begin
        pending_next = pending_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        byte0_next   = byte0_reg;
        byte1_next   = byte1_reg;
        byte2_next   = byte2_reg;
        wait_next    = wait_reg;
        job_push     = 1'b0;
        job.kind     = urm_pkg::JOB_READ;
        job.addr     = in_addr;
        job.data     = in_value;
        job.aux      = write_cs;
        finish       = 1'b0;
        check_byte   = 8'h00;

        if (in_accept) begin
            unique case (in_op)
                urm_pkg::OP_READ, urm_pkg::OP_WRITE: begin
                    pending_next = (in_op == urm_pkg::OP_READ);
                    if (in_op == urm_pkg::OP_READ) begin
                        addr_next = in_addr;
                    end
                    count_next = 2'd0;
                    byte0_next = 8'h00;
                    byte1_next = 8'h00;
                    byte2_next = 8'h00;
                    wait_next  = 16'd0;
                    job_push   = 1'b1;
                    job.kind   = (in_op == urm_pkg::OP_READ) ? urm_pkg::JOB_READ
                                                               : urm_pkg::JOB_WRITE;
                end
                urm_pkg::OP_RXB: begin
                    if (pending_reg) begin
                        unique case (count_reg)
                            2'd0: byte0_next = in_rx;
                            2'd1: byte1_next = in_rx;
                            2'd2: byte2_next = in_rx;
                            default: begin
                                finish     = 1'b1;
                                check_byte = in_rx;
                            end
                        endcase
                        count_next = count_reg + 2'd1;
                    end
                end
                default: begin
                    if (pending_reg) begin
                        if (wait_reg >= timeout_reg) begin
                            if (count_reg == 2'd0) begin
                                job_push = 1'b1;
                                job.kind = urm_pkg::JOB_FAIL;
                                job.aux  = {7'd0, urm_pkg::ERR_TIMEOUT};
                            end else begin
                                finish = 1'b1;
                            end
                        end else begin
                            wait_next = wait_reg + 16'd1;
                        end
                    end
                end
            endcase

            if (finish) begin
                job_push = 1'b1;
                if (reply_cs == check_byte) begin
                    job.kind = urm_pkg::JOB_DONE;
                    job.data = {byte2_reg, byte1_reg, byte0_reg};
                end else begin
                    job.kind = urm_pkg::JOB_FAIL;
                    job.aux  = {7'd0, urm_pkg::ERR_CHECKSUM};
                end
            end

            if (job_push && (job.kind == urm_pkg::JOB_DONE || job.kind == urm_pkg::JOB_FAIL))
            begin
                pending_next = 1'b0;
                count_next   = 2'd0;
                byte0_next   = 8'h00;
                byte1_next   = 8'h00;
                byte2_next   = 8'h00;
                wait_next    = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= urm_pkg::TIMEOUT_RESET;
            pending_reg <= 1'b0;
            addr_reg    <= 8'h00;
            count_reg   <= 2'd0;
            byte0_reg   <= 8'h00;
            byte1_reg   <= 8'h00;
            byte2_reg   <= 8'h00;
            wait_reg    <= 16'd0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            pending_reg <= pending_next;
            addr_reg    <= addr_next;
            count_reg   <= count_next;
            byte0_reg   <= byte0_next;
            byte1_reg   <= byte1_next;
            byte2_reg   <= byte2_next;
            wait_reg    <= wait_next;
        end
    end

endmodule

// ----- rtl/core/urm_queue.sv -----
`timescale 1ns / 1ps

module urm_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  urm_pkg::job_t  push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output urm_pkg::job_t  head_job
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    urm_pkg::job_t  slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/core/urm_back.sv -----
`timescale 1ns / 1ps

module urm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  urm_pkg::job_t                   head_job,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [urm_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    logic [3:0]  step_reg;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  tx_reg;
    logic [23:0] value_reg;
    logic        err_reg;
    logic        last_reg;

    logic        load;
    logic [3:0]  last_step;
    logic [1:0]  kind_c;
    logic [7:0]  tx_c;
    logic [23:0] value_c;
    logic        err_c;

    assign load = head_valid && (!valid_reg || m_tready);

    always_comb begin
        kind_c    = urm_pkg::KIND_TX;
        tx_c      = 8'h00;
        value_c   = 24'd0;
        err_c     = 1'b0;
        last_step = 4'd0;
        unique case (head_job.kind)
            urm_pkg::JOB_READ: begin
                last_step = 4'd1;
                tx_c = (step_reg == 4'd0) ? urm_pkg::HDR_READ : head_job.addr;
            end
            urm_pkg::JOB_WRITE: begin
                last_step = 4'd11;
                unique case (step_reg)
                    4'd0:    tx_c = urm_pkg::HDR_WRITE;
                    4'd1:    tx_c = urm_pkg::UNLOCK_REG;
                    4'd2:    tx_c = urm_pkg::UNLOCK_KEY;
                    4'd3:    tx_c = 8'h00;
                    4'd4:    tx_c = 8'h00;
                    4'd5:    tx_c = urm_pkg::UNLOCK_CS;
                    4'd6:    tx_c = urm_pkg::HDR_WRITE;
                    4'd7:    tx_c = head_job.addr;
                    4'd8:    tx_c = head_job.data[7:0];
                    4'd9:    tx_c = head_job.data[15:8];
                    4'd10:   tx_c = head_job.data[23:16];
                    default: tx_c = head_job.aux;
                endcase
            end
            urm_pkg::JOB_DONE: begin
                kind_c  = urm_pkg::KIND_DONE;
                value_c = head_job.data;
            end
            default: begin
                kind_c = urm_pkg::KIND_FAIL;
                err_c  = head_job.aux[0];
            end
        endcase
    end

    assign pop = load && (step_reg == last_step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                step_reg  <= (step_reg == last_step) ? 4'd0 : step_reg + 4'd1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_c;
            tx_reg    <= tx_c;
            value_reg <= value_c;
            err_reg   <= err_c;
            last_reg  <= (step_reg == last_step);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'd0, err_reg, value_reg, tx_reg};

endmodule

// ----- rtl/core/uart_register_access_master.sv -----
`timescale 1ns / 1ps
// Host-side register access master for a byte-serial metering protocol.
// Slave channel: one transaction per command. s_tuser = operation (read, write,
// received byte, tick); s_tdata carries address, write value and received byte.
// Master channel: one transaction per result. m_tuser = kind (byte to transmit,
// read completed, read failed); m_tlast marks the final result of a command.
// A write produces 12 frame bytes (unlock frame, then write frame), a read
// start produces 2, and a finished, failed or timed-out read produces 1.
// With the queue empty, a command's job is written into the job queue and
// then loaded into the output register, which raises m_tvalid.
// The front end takes one transaction per cycle while the job queue
// (QUEUE_DEPTH entries) has room; the back end emits one result per cycle
// while the receiver does not stall the output.
// When the receiver stalls, the output register holds, the queue fills and
// s_tready drops, which also holds off received bytes and ticks.
// Reset (aresetn low, synchronous) empties the queue and output, drops any
// pending read and sets timeout_ticks back to 100. cfg_we writes timeout_ticks.
module uart_register_access_master #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [15:0]                     cfg_wdata,     // timeout_ticks
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [urm_pkg::IN_DATA_W-1:0]   s_tdata,       // reg_address, write_value, rx_byte
    input  logic [1:0]                      s_tuser,       // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [urm_pkg::OUT_DATA_W-1:0]  m_tdata,       // tx_byte, read_value, error_code, pad
    output logic [1:0]                      m_tuser,       // kind
    output logic                            m_tlast
);

    logic          full;
    logic          job_push;
    urm_pkg::job_t job;
    logic          head_valid;
    urm_pkg::job_t head_job;
    logic          pop;

    assign s_tready = !full;

    urm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (s_tvalid && s_tready),
        .in_op     (s_tuser),
        .in_addr   (s_tdata[7:0]),
        .in_value  (s_tdata[31:8]),
        .in_rx     (s_tdata[39:32]),
        .job_push  (job_push),
        .job       (job)
    );

    urm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    urm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- rtl/core/urm_checker.sv -----
`timescale 1ns / 1ps

module urm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [urm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [1:0]                      m_tuser,
    input logic                            m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output transaction changed");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == urm_pkg::KIND_TX || m_tuser == urm_pkg::KIND_DONE
                     || m_tuser == urm_pkg::KIND_FAIL)
        else $error("undefined result kind");

    a_report_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != urm_pkg::KIND_TX |-> m_tlast)
        else $error("read report not marked last");

    a_tx_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == urm_pkg::KIND_TX |-> m_tdata[urm_pkg::OUT_DATA_W-1:8] == '0)
        else $error("transmit byte carries value or error bits");

endmodule

bind uart_register_access_master urm_checker u_urm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
